// File: rtl/sgs_pkg.sv
package sgs_pkg;

    // Field and register widths of the block's ports.
    localparam int PIX_W       = 8;
    localparam int GRAD_W      = 10;
    localparam int FW_W        = 11;
    localparam int FH_W        = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Register values after reset.
    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // Line store depth default, window size and pixel depth in use.
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int KERNEL_SIZE       = 3;
    localparam int PIXEL_BITS        = 8;
    localparam logic [PIX_W-1:0] PIXEL_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

    // Largest gradient magnitude that the result fields carry.
    localparam logic [GRAD_W-1:0] GRAD_MAX = 10'd1023;

    // Queue depths between front and back, and on the result side.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // What the front part decides for one request.
    typedef struct packed {
        logic [PIX_W-1:0] data;   // pixel value, zero for pad slots
        logic             emit;   // the request produces a result
        logic             calc;   // the result is an interior pixel
        logic             last;   // final result of the frame
    } item_flags_t;

    // One result as it waits in the output queue.
    typedef struct packed {
        logic [GRAD_W-1:0] grad_x;
        logic [GRAD_W-1:0] grad_y;
        logic              frame_end;
    } result_t;

endpackage

// File: rtl/sgs_fifo.sv
module sgs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    // Pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

endmodule

// File: rtl/sgs_front.sv
module sgs_front #(
    parameter int MAX_WIDTH = sgs_pkg::DEFAULT_MAX_WIDTH,
    parameter int AW        = $clog2(sgs_pkg::DEFAULT_MAX_WIDTH)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [sgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sgs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    input  logic                             kind,
    input  logic [sgs_pkg::PIX_W-1:0]        pixel,
    output logic [AW-1:0]                    addr,
    output sgs_pkg::item_flags_t             flags
);

    import sgs_pkg::*;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [FW_W-1:0] col_pos_reg;
    logic [FH_W-1:0] row_pos_reg;
    logic [FW_W-1:0] col_pos_next;
    logic [FH_W-1:0] row_pos_next;
    logic            row_done;
    logic            frame_done;
    logic            pad;

    // Classify the slot at the current raster position.
    always_comb
    begin
        row_done   = (col_pos_reg >= frame_width_reg);
        frame_done = (row_pos_reg >= frame_height_reg);
        pad        = row_done || frame_done;
        flags.data = (kind || pad) ? '0 : (pixel & PIXEL_MASK);
        flags.emit = (row_pos_reg != '0) && (col_pos_reg != '0);
        flags.calc = (row_pos_reg >= FH_W'(2)) && !frame_done &&
                     (col_pos_reg >= FW_W'(2)) && !row_done;
        flags.last = row_done && frame_done;
    end

    // Line store column, held at the last entry beyond the store's width.
    always_comb
    begin
        if (int'(col_pos_reg) >= MAX_WIDTH - 1)
        begin
            addr = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            addr = AW'(col_pos_reg);
        end
    end

    // Raster position after this slot.
    always_comb
    begin
        col_pos_next = FW_W'(col_pos_reg + 1'b1);
        row_pos_next = row_pos_reg;
        if (row_done)
        begin
            col_pos_next = '0;
            row_pos_next = frame_done ? '0 : FH_W'(row_pos_reg + 1'b1);
        end
    end

    // Position counters and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else
        begin
            if (accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

// File: rtl/sgs_back.sv
module sgs_back #(
    parameter int MAX_WIDTH = sgs_pkg::DEFAULT_MAX_WIDTH,
    parameter int AW        = $clog2(sgs_pkg::DEFAULT_MAX_WIDTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [AW-1:0]         in_addr,
    input  sgs_pkg::item_flags_t  in_flags,
    output logic                  in_take,
    input  logic                  out_room,
    output logic                  out_push,
    output sgs_pkg::result_t      out_result,
    output logic                  clearing
);

    import sgs_pkg::*;

    localparam int K = KERNEL_SIZE;

    // Line store: each entry holds the older row above the newer row.
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    logic               clear_reg;
    logic [AW-1:0]      clear_cnt_reg;

    logic               s1_valid_reg;
    logic [AW-1:0]      s1_addr_reg;
    item_flags_t        s1_flags_reg;

    logic [PIX_W-1:0]   win_reg [K][K];

    logic               s2_valid_reg;
    logic               s2_emit_reg;
    logic               s2_calc_reg;
    logic               s2_last_reg;
    logic signed [8:0]  dx_reg [K];
    logic signed [8:0]  dy_reg [K];
    logic signed [8:0]  dx_next [K];
    logic signed [8:0]  dy_next [K];

    logic               adv;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [2*PIX_W-1:0] wr_data;
    logic [PIX_W-1:0]   new_col [K];
    logic signed [11:0] sum_x;
    logic signed [11:0] sum_y;

    // Magnitude of a signed sum, clamped to the result width.
    function automatic logic [GRAD_W-1:0] abs_sat(input logic signed [11:0] v);
        logic [11:0] mag;
        mag = v[11] ? 12'(-v) : 12'(v);
        return (mag > 12'(GRAD_MAX)) ? GRAD_MAX : mag[GRAD_W-1:0];
    endfunction

    // The whole back pipeline moves together when the output queue has room and no clearing sweep runs.
    assign adv      = out_room && !clear_reg;
    assign in_take  = adv && in_valid;
    assign clearing = clear_reg;

    // One write per cycle: the clearing sweep, or the row shift of stage one.
    always_comb
    begin
        wr_en   = clear_reg || (adv && s1_valid_reg);
        wr_addr = clear_reg ? clear_cnt_reg : s1_addr_reg;
        wr_data = clear_reg ? '0 : {rd_reg[PIX_W-1:0], s1_flags_reg.data};
    end

    // Line store with a registered read that sees a write to the same column.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (in_take)
        begin
            if (wr_en && (wr_addr == in_addr))
            begin
                rd_reg <= wr_data;
            end
            else
            begin
                rd_reg <= mem[in_addr];
            end
        end
    end

    // Clearing sweep after reset, one entry a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clear_cnt_reg == AW'(MAX_WIDTH - 1))
            begin
                clear_reg <= 1'b0;
            end
            else
            begin
                clear_cnt_reg <= AW'(clear_cnt_reg + 1'b1);
            end
        end
    end

    // New window column, then the row and column differences of the new window.
    always_comb
    begin
        new_col[0] = rd_reg[2*PIX_W-1:PIX_W];
        new_col[1] = rd_reg[PIX_W-1:0];
        new_col[2] = s1_flags_reg.data;
        for (int r = 0; r < K; r++)
        begin
            dx_next[r] = $signed({1'b0, new_col[r]}) - $signed({1'b0, win_reg[r][1]});
        end
        dy_next[0] = $signed({1'b0, win_reg[2][1]}) - $signed({1'b0, win_reg[0][1]});
        dy_next[1] = $signed({1'b0, win_reg[2][2]}) - $signed({1'b0, win_reg[0][2]});
        dy_next[2] = $signed({1'b0, new_col[2]}) - $signed({1'b0, new_col[0]});
    end

    // Stage one: window shift and differences; stage two holds them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int r = 0; r < K; r++)
            begin
                for (int c = 0; c < K; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < K; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                    win_reg[r][2] <= new_col[r];
                end
            end
        end
    end

    // Payload of the two stages.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_addr_reg  <= in_addr;
            s1_flags_reg <= in_flags;
        end
        if (adv && s1_valid_reg)
        begin
            s2_emit_reg <= s1_flags_reg.emit;
            s2_calc_reg <= s1_flags_reg.calc;
            s2_last_reg <= s1_flags_reg.last;
            for (int i = 0; i < K; i++)
            begin
                dx_reg[i] <= dx_next[i];
                dy_reg[i] <= dy_next[i];
            end
        end
    end

    // Stage two: weighted sums, magnitude and the border rule.
    always_comb
    begin
        sum_x = 12'(dx_reg[0]) + (12'(dx_reg[1]) <<< 1) + 12'(dx_reg[2]);
        sum_y = 12'(dy_reg[0]) + (12'(dy_reg[1]) <<< 1) + 12'(dy_reg[2]);
        out_result.grad_x    = s2_calc_reg ? abs_sat(sum_x) : '0;
        out_result.grad_y    = s2_calc_reg ? abs_sat(sum_y) : '0;
        out_result.frame_end = s2_last_reg;
        out_push             = adv && s2_valid_reg && s2_emit_reg;
    end

endmodule

// File: rtl/sobel_gradient_stream.sv
// Streaming 3x3 Sobel gradient unit. Pixels arrive in raster order through
// push/full, one request per slot of a frame of (frame_height+1) rows of
// (frame_width+1) slots, the last column and last row being pad slots; the
// absolute horizontal and vertical gradients leave through empty/pop, one
// result for every slot with row and column both at least one, each result
// belonging to the pixel one row up and one column left, zero on the frame
// border, and frame_end marks the last one of a frame. The block takes one
// request per clock while full is low and gives at most one result per clock;
// between a request and its result lie the queue between front and back,
// the registered read of the line store (a single memory of MAX_WIDTH
// entries with one write and one read per cycle) together with the window
// difference stage, and the result queue. After reset the line store is
// cleared, during which full stays high; configuration writes are taken
// at any time but belong in the gaps between frames.
module sobel_gradient_stream #(
    parameter int MAX_WIDTH = sgs_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [sgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sgs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic                             kind,
    input  logic [sgs_pkg::PIX_W-1:0]        pixel,
    output logic                             empty,
    input  logic                             pop,
    output logic [sgs_pkg::GRAD_W-1:0]       grad_x,
    output logic [sgs_pkg::GRAD_W-1:0]       grad_y,
    output logic                             frame_end
);

    import sgs_pkg::*;

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MID_W = AW + $bits(item_flags_t);
    localparam int RES_W = $bits(result_t);

    logic              accept;
    logic              mid_full;
    logic              mid_empty;
    logic              clearing;
    logic [AW-1:0]     front_addr;
    item_flags_t       front_flags;
    logic [MID_W-1:0]  mid_head;
    logic [AW-1:0]     back_addr;
    item_flags_t       back_flags;
    logic              back_take;
    logic              out_full;
    logic              out_push;
    result_t           back_result;
    result_t           out_head;
    logic [RES_W-1:0]  out_head_bits;

    // Requests are held off while the line store is cleared.
    assign full   = mid_full || clearing;
    assign accept = push && !full;

    // Front: raster position, configuration and slot classification.
    sgs_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (kind),
        .pixel     (pixel),
        .addr      (front_addr),
        .flags     (front_flags)
    );

    // Short queue between the front and the back.
    sgs_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({front_addr, front_flags}),
        .full      (mid_full),
        .pop       (back_take),
        .pop_data  (mid_head),
        .empty     (mid_empty)
    );

    assign back_addr  = mid_head[MID_W-1 -: AW];
    assign back_flags = item_flags_t'(mid_head[$bits(item_flags_t)-1:0]);

    // Back: line store, window and gradient arithmetic.
    sgs_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!mid_empty),
        .in_addr    (back_addr),
        .in_flags   (back_flags),
        .in_take    (back_take),
        .out_room   (!out_full),
        .out_push   (out_push),
        .out_result (back_result),
        .clearing   (clearing)
    );

    // Result queue that parts the back from the consumer.
    sgs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (back_result),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_head_bits),
        .empty     (empty)
    );

    assign out_head  = result_t'(out_head_bits);
    assign grad_x    = out_head.grad_x;
    assign grad_y    = out_head.grad_y;
    assign frame_end = out_head.frame_end;

endmodule

// File: rtl/sgs_checker.sv
module sgs_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             full,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [sgs_pkg::GRAD_W-1:0]       grad_x,
    input  logic [sgs_pkg::GRAD_W-1:0]       grad_y,
    input  logic                             frame_end
);

    import sgs_pkg::*;

    localparam logic [GRAD_W-1:0] GRADIENT_BOUND = GRAD_W'(4 * int'(PIXEL_MASK));

    // Coming out of reset the result side is empty and requests are held off.
    a_reset_state: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && full))
        else $error("result waiting or input open straight after reset");

    // A waiting result that is not taken stays as it is.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(grad_x) && $stable(grad_y) &&
                              $stable(frame_end)))
        else $error("waiting result changed or vanished without a pop");

    // The last result of a frame lies on the border, so its gradients are zero.
    a_frame_end_border: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> (grad_x == '0 && grad_y == '0))
        else $error("frame end result carries a non-zero gradient");

    // Four times the largest pixel bounds each gradient.
    a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (grad_x <= GRADIENT_BOUND && grad_y <= GRADIENT_BOUND))
        else $error("gradient above the kernel's largest response");

endmodule

bind sobel_gradient_stream sgs_checker u_checker (.*);

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sgs_pkg::*;

    localparam int LINE_DEPTH    = DEFAULT_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 480;
    localparam int REPORT_CAP    = 100;

    // One pixel request as the sender presents it.
    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
    } slot_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic               kind = 1'b0;
    logic [PIX_W-1:0]   pixel = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [GRAD_W-1:0]  grad_x;
    logic [GRAD_W-1:0]  grad_y;
    logic               frame_end;

    // Requests waiting to be sent and gradients waiting to come out.
    slot_t   pixel_backlog[$];
    result_t pending_gradients[$];

    // Shadow of the block: line stores, window, slot position and geometry.
    logic [PIX_W-1:0] line_upper [LINE_DEPTH];
    logic [PIX_W-1:0] line_lower [LINE_DEPTH];
    logic [PIX_W-1:0] window_px [KERNEL_SIZE][KERNEL_SIZE];
    logic [FH_W-1:0]  exp_row = '0;
    logic [FW_W-1:0]  exp_col = '0;
    logic [FW_W-1:0]  exp_width = FRAME_WIDTH_RESET;
    logic [FH_W-1:0]  exp_height = FRAME_HEIGHT_RESET;

    int   send_idle_pct = 0;
    int   take_idle_pct = 0;
    logic push_taken = 1'b0;
    int   mismatch_count = 0;

    sobel_gradient_stream u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .frame_end (frame_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Magnitude of a kernel sum, clipped to what the result fields carry.
    function automatic logic [GRAD_W-1:0] grad_mag(input int v);
        int m;
        m = (v < 0) ? -v : v;
        return (m > int'(GRAD_MAX)) ? GRAD_MAX : GRAD_W'(m);
    endfunction

    // Advance the shadow by one accepted request and queue the gradient it yields.
    task automatic predict_gradients(input logic k, input logic [PIX_W-1:0] p);
        logic             pad;
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        int               ci;
        int               sx;
        int               sy;
        result_t          r;
        pad = (exp_col >= exp_width) || (exp_row >= exp_height);
        d = (k || pad) ? '0 : (p & PIXEL_MASK);
        ci = (int'(exp_col) < LINE_DEPTH) ? int'(exp_col) : LINE_DEPTH - 1;
        top = line_upper[ci];
        mid = line_lower[ci];
        line_upper[ci] = mid;
        line_lower[ci] = d;
        for (int rr = 0; rr < KERNEL_SIZE; rr++)
        begin
            window_px[rr][0] = window_px[rr][1];
            window_px[rr][1] = window_px[rr][2];
        end
        window_px[0][2] = top;
        window_px[1][2] = mid;
        window_px[2][2] = d;

        if (exp_row >= 1 && exp_col >= 1)
        begin
            r = '0;
            r.frame_end = (exp_col >= exp_width) && (exp_row >= exp_height);
            // Only interior pixels get a kernel response; the border stays zero.
            if (exp_row >= 2 && exp_row < exp_height && exp_col >= 2 && exp_col < exp_width)
            begin
                sx = -int'(window_px[0][0]) + int'(window_px[0][2])
                     - 2 * int'(window_px[1][0]) + 2 * int'(window_px[1][2])
                     - int'(window_px[2][0]) + int'(window_px[2][2]);
                sy = -int'(window_px[0][0]) - 2 * int'(window_px[0][1])
                     - int'(window_px[0][2]) + int'(window_px[2][0])
                     + 2 * int'(window_px[2][1]) + int'(window_px[2][2]);
                r.grad_x = grad_mag(sx);
                r.grad_y = grad_mag(sy);
            end
            pending_gradients.push_back(r);
        end

        if (exp_col >= exp_width)
        begin
            exp_col = '0;
            exp_row = (exp_row >= exp_height) ? '0 : exp_row + 1'b1;
        end
        else
        begin
            exp_col = exp_col + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        // Printing is capped so that a broken block cannot flood the log.
        if (mismatch_count < REPORT_CAP)
            $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Sender: a request is held until taken, then replaced or withdrawn.
    always @(negedge clk)
    begin : request_driver
        slot_t next_slot;
        if (rst_n && (!push || push_taken))
        begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_slot = pixel_backlog.pop_front();
                push  <= 1'b1;
                kind  <= next_slot.kind;
                pixel <= next_slot.pixel;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: pop is raised or held back at random.
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(0, 99) >= take_idle_pct);
    end

    // Predict on every accepted request and check every accepted result.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            push_taken = push && !full;
            if (push_taken)
                predict_gradients(kind, pixel);
            if (pop && !empty)
            begin
                if (pending_gradients.size() == 0)
                begin
                    report_mismatch("unexpected result, grad_x", int'(grad_x), 0);
                end
                else
                begin
                    want = pending_gradients.pop_front();
                    if (grad_x !== want.grad_x)
                        report_mismatch("grad_x", int'(grad_x), int'(want.grad_x));
                    if (grad_y !== want.grad_y)
                        report_mismatch("grad_y", int'(grad_y), int'(want.grad_y));
                    if (frame_end !== want.frame_end)
                        report_mismatch("frame_end", int'(frame_end),
                                        int'(want.frame_end));
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("sobel_gradient_stream test failed");
        $finish;
    end

    task automatic queue_slot(input logic k, input logic [PIX_W-1:0] p);
        slot_t s;
        s.kind  = k;
        s.pixel = p;
        pixel_backlog.push_back(s);
    endtask

    // Wait until every request is taken and every result has come out, then let
    // any request that yields no result clear the pipeline.
    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || push || pending_gradients.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Set the frame geometry; only ever called with the block idle.
    task automatic write_geometry(input logic [FW_W-1:0] w, input logic [FH_W-1:0] h);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        // The spare top bit of the data port must be ignored for the width.
        cfg_data  <= {1'($urandom_range(0, 1)), w};
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_write <= 1'b0;
        exp_width  = w;
        exp_height = h;
        @(posedge clk);
    endtask

    // Queue requests that follow the frame layout from the current slot position:
    // padding at pad slots, pixels elsewhere, with a share of kinds flipped.
    task automatic queue_slots(input int count, input int noise_pct, input logic binary);
        logic [FH_W-1:0]  gen_row;
        logic [FW_W-1:0]  gen_col;
        logic             pad;
        logic             k;
        logic [PIX_W-1:0] p;
        gen_row = exp_row;
        gen_col = exp_col;
        for (int i = 0; i < count; i++)
        begin
            pad = (gen_col >= exp_width) || (gen_row >= exp_height);
            k = ($urandom_range(0, 99) < noise_pct) ? !pad : pad;
            if (binary)
                p = $urandom_range(0, 1) ? '1 : '0;
            else
                case ($urandom_range(0, 7))
                    0: p = '0;
                    1: p = '1;
                    default: p = PIX_W'($urandom_range(0, 255));
                endcase
            queue_slot(k, p);
            if (gen_col >= exp_width)
            begin
                gen_col = '0;
                gen_row = (gen_row >= exp_height) ? '0 : gen_row + 1'b1;
            end
            else
            begin
                gen_col = gen_col + 1'b1;
            end
        end
    endtask

    // Small random frames, some cut off part-way, some pure black and white.
    task automatic run_random_frames(input int budget);
        int done;
        int w;
        int h;
        int n;
        done = 0;
        while (done < budget)
        begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            write_geometry(FW_W'(w), FH_W'(h));
            n = $urandom_range(1, 2) * (w + 1) * (h + 1);
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            queue_slots(n, ($urandom_range(0, 3) == 0) ? 25 : 3, $urandom_range(0, 3) == 0);
            wait_idle();
            done += n;
        end
    endtask

    initial
    begin
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        for (int rr = 0; rr < KERNEL_SIZE; rr++)
            for (int cc = 0; cc < KERNEL_SIZE; cc++)
                window_px[rr][cc] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        take_idle_pct = 72;

        // Directed 3x3 frame: black left column and white right column give the
        // largest horizontal response; one real slot is flagged as padding, and
        // several pad slots carry kind 0 with bright data that must read as zero.
        write_geometry(3, 3);
        queue_slot(1'b0, 8'd0);   queue_slot(1'b1, 8'd255); queue_slot(1'b0, 8'd255);
        queue_slot(1'b1, 8'd17);
        queue_slot(1'b0, 8'd0);   queue_slot(1'b0, 8'd77);  queue_slot(1'b0, 8'd255);
        queue_slot(1'b0, 8'd255);
        queue_slot(1'b0, 8'd0);   queue_slot(1'b0, 8'd200); queue_slot(1'b0, 8'd255);
        queue_slot(1'b1, 8'd0);
        queue_slot(1'b0, 8'd255); queue_slot(1'b1, 8'd255); queue_slot(1'b0, 8'd128);
        queue_slot(1'b0, 8'd255);
        queue_slot(1'b0, 8'd255); queue_slot(1'b0, 8'd255); queue_slot(1'b0, 8'd255);
        queue_slot(1'b1, 8'd0);
        wait_idle();

        run_random_frames(RANDOM_ITEMS / 3);

        // Default geometry over a little more than two rows.
        write_geometry(FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET);
        queue_slots(1290, 2, 1'b0);
        wait_idle();

        send_idle_pct = 72;
        take_idle_pct = 29;

        // Tallest frame, left part-way through so the next geometry cuts in.
        write_geometry(11'd3, 12'd4095);
        queue_slots(100, 2, 1'b0);
        wait_idle();

        run_random_frames(RANDOM_ITEMS / 3);

        send_idle_pct = 0;
        take_idle_pct = 0;

        // Degenerate geometries below the usual range.
        write_geometry(11'd1, 12'd2);
        queue_slots(14, 0, 1'b0);
        wait_idle();
        write_geometry(11'd0, 12'd3);
        queue_slots(6, 0, 1'b0);
        wait_idle();
        write_geometry(11'd2, 12'd0);
        queue_slots(9, 0, 1'b0);
        wait_idle();
        write_geometry(11'd2, 12'd1);
        queue_slots(10, 0, 1'b0);
        wait_idle();

        run_random_frames(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_idle();

        if (mismatch_count == 0 && pending_gradients.size() == 0)
            $display("sobel_gradient_stream test passed");
        else
            $display("sobel_gradient_stream test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sgs_pkg.sv
rtl/sgs_fifo.sv
rtl/sgs_front.sv
rtl/sgs_back.sv
rtl/sobel_gradient_stream.sv
rtl/sgs_checker.sv
sim/testbench.sv
